>>> rtl/core/bpi_pkg.sv
// shared types, constants and micro-program for the biomorph pixel iterator
package bpi_pkg;

    localparam int DEF_MAX_ITER = 50;

    // working value format: signed q24.40 in 64 bits
    localparam int VAL_W      = 64;
    localparam int FRAC_SHIFT = 16;

    localparam logic signed [VAL_W-1:0] SAT_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [VAL_W-1:0] SAT_MIN = 64'sh8000_0000_0000_0001;
    localparam logic signed [VAL_W-1:0] LIM_RUN = 64'sd80 <<< 40;
    localparam logic signed [VAL_W-1:0] LIM_RE  = 64'sd50 <<< 40;
    localparam logic signed [VAL_W-1:0] LIM_IM  = 64'sd2500 <<< 40;

    // configuration register indexes
    localparam logic [2:0] REG_CONST_RE = 3'd0;
    localparam logic [2:0] REG_CONST_IM = 3'd1;
    localparam logic [2:0] REG_OFFSET_X = 3'd2;
    localparam logic [2:0] REG_OFFSET_Y = 3'd3;
    localparam logic [2:0] REG_ZOOM     = 3'd4;
    localparam logic [2:0] REG_STEP     = 3'd5;

    // micro-op kinds
    localparam logic [1:0] OP_MUL = 2'd0;
    localparam logic [1:0] OP_ADD = 2'd1;
    localparam logic [1:0] OP_SUB = 2'd2;

    // operand / destination codes
    localparam logic [3:0] SRC_RE   = 4'd0;
    localparam logic [3:0] SRC_IM   = 4'd1;
    localparam logic [3:0] SRC_RE2  = 4'd2;
    localparam logic [3:0] SRC_IM2  = 4'd3;
    localparam logic [3:0] SRC_P    = 4'd4;
    localparam logic [3:0] SRC_Q    = 4'd5;
    localparam logic [3:0] SRC_T    = 4'd6;
    localparam logic [3:0] SRC_CRE  = 4'd7;
    localparam logic [3:0] SRC_CIM  = 4'd8;
    localparam logic [3:0] SRC_ZOOM = 4'd9;

    localparam int         PC_W    = 4;
    localparam logic [3:0] LAST_PC = 4'd15;

    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] dst;
        logic [3:0] srca;
        logic [3:0] srcb;
        logic       absa;
    } uop_t;

    typedef struct packed {
        logic signed [31:0] const_re;
        logic signed [31:0] const_im;
        logic signed [31:0] offset_x;
        logic signed [31:0] offset_y;
        logic [30:0]        zoom_factor;
        logic [30:0]        pixel_step;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic start;
        uop_t op;
    } cmd_t;

    typedef struct packed {
        logic run;
        logic hit;
        logic done;
    } stat_t;

    // one cubic step: re = |Re(z^3 + c)| * zoom, im = |Im(z^3 + c)| * zoom
    function automatic uop_t prog_rom(input logic [PC_W-1:0] pc);
        uop_t u;
        unique case (pc)
            4'd0:  u = '{OP_MUL, SRC_RE2, SRC_RE,  SRC_RE,   1'b0};
            4'd1:  u = '{OP_MUL, SRC_IM2, SRC_IM,  SRC_IM,   1'b0};
            4'd2:  u = '{OP_MUL, SRC_P,   SRC_RE2, SRC_RE,   1'b0};
            4'd3:  u = '{OP_MUL, SRC_Q,   SRC_RE,  SRC_IM2,  1'b0};
            4'd4:  u = '{OP_ADD, SRC_T,   SRC_Q,   SRC_Q,    1'b0};
            4'd5:  u = '{OP_ADD, SRC_T,   SRC_T,   SRC_Q,    1'b0};
            4'd6:  u = '{OP_SUB, SRC_P,   SRC_P,   SRC_T,    1'b0};
            4'd7:  u = '{OP_ADD, SRC_P,   SRC_P,   SRC_CRE,  1'b0};
            4'd8:  u = '{OP_MUL, SRC_Q,   SRC_RE2, SRC_IM,   1'b0};
            4'd9:  u = '{OP_ADD, SRC_T,   SRC_Q,   SRC_Q,    1'b0};
            4'd10: u = '{OP_ADD, SRC_T,   SRC_T,   SRC_Q,    1'b0};
            4'd11: u = '{OP_MUL, SRC_Q,   SRC_IM2, SRC_IM,   1'b0};
            4'd12: u = '{OP_SUB, SRC_T,   SRC_T,   SRC_Q,    1'b0};
            4'd13: u = '{OP_ADD, SRC_T,   SRC_T,   SRC_CIM,  1'b0};
            4'd14: u = '{OP_MUL, SRC_RE,  SRC_P,   SRC_ZOOM, 1'b1};
            4'd15: u = '{OP_MUL, SRC_IM,  SRC_T,   SRC_ZOOM, 1'b1};
        endcase
        return u;
    endfunction

endpackage

>>> rtl/core/bpi_datapath.sv
// datapath: working registers, saturating adder and multi-cycle q24.40 multiplier
module bpi_datapath
(
    input  logic               clk,
    input  logic               rst_n,
    input  bpi_pkg::cfg_t      cfg,
    input  bpi_pkg::cmd_t      cmd,
    input  logic signed [9:0]  pixel_x,
    input  logic signed [9:0]  pixel_y,
    output bpi_pkg::stat_t     stat
);
    import bpi_pkg::*;

    function automatic logic signed [VAL_W-1:0] sat_add(
        input logic signed [VAL_W-1:0] a,
        input logic signed [VAL_W-1:0] b
    );
        logic signed [VAL_W:0] s;
        s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
        if (!s[VAL_W] && s[VAL_W-1])
            return SAT_MAX;
        else if (s[VAL_W] && (!s[VAL_W-1] || s[VAL_W-1:0] == {1'b1, {(VAL_W-1){1'b0}}}))
            return SAT_MIN;
        else
            return s[VAL_W-1:0];
    endfunction

    logic signed [VAL_W-1:0] re_reg, re_next, im_reg, im_next;
    logic signed [VAL_W-1:0] re2_reg, im2_reg, p_reg, q_reg, t_reg;

    logic [VAL_W-1:0]        x_reg, y_reg;
    logic                    neg_reg;
    logic [2*VAL_W-1:0]      acc_reg;
    logic [VAL_W-1:0]        prod_reg;
    logic [1:0]              sh_reg;
    logic [2:0]              mcnt_reg;
    logic                    mbusy_reg;
    logic                    add_done_reg;
    logic [3:0]              dst_reg;

    logic signed [VAL_W-1:0] opa, opb, add_res, mul_res, wdata;
    logic [3:0]              wdst;
    logic                    we;
    logic [31:0]             xs, ys;
    logic [2*VAL_W-1:0]      prod_sh;
    logic [VAL_W-1:0]        mul_mag;

    // start point: |(pixel * step + offset) << 16|
    logic signed [41:0]      step_ext, sx, sy;
    logic signed [VAL_W-1:0] x0, y0;

    function automatic logic signed [VAL_W-1:0] pick(
        input logic [3:0]       src,
        input logic signed [VAL_W-1:0] vre, vim, vre2, vim2, vp, vq, vt,
        input cfg_t             c
    );
        logic signed [VAL_W-1:0] v;
        unique case (src)
            SRC_RE:   v = vre;
            SRC_IM:   v = vim;
            SRC_RE2:  v = vre2;
            SRC_IM2:  v = vim2;
            SRC_P:    v = vp;
            SRC_Q:    v = vq;
            SRC_T:    v = vt;
            SRC_CRE:  v = VAL_W'(c.const_re) <<< FRAC_SHIFT;
            SRC_CIM:  v = VAL_W'(c.const_im) <<< FRAC_SHIFT;
            SRC_ZOOM: v = VAL_W'({1'b0, c.zoom_factor}) <<< FRAC_SHIFT;
            default:  v = '0;
        endcase
        return v;
    endfunction

    always_comb
    begin
        step_ext = 42'($signed({1'b0, cfg.pixel_step}));
        sx = 42'(pixel_x) * step_ext + 42'(cfg.offset_x);
        sy = 42'(pixel_y) * step_ext + 42'(cfg.offset_y);
        x0 = VAL_W'(sx) <<< FRAC_SHIFT;
        y0 = VAL_W'(sy) <<< FRAC_SHIFT;
        if (x0 < 0)
            x0 = -x0;
        if (y0 < 0)
            y0 = -y0;

        opa = pick(cmd.op.srca, re_reg, im_reg, re2_reg, im2_reg, p_reg, q_reg, t_reg, cfg);
        opb = pick(cmd.op.srcb, re_reg, im_reg, re2_reg, im2_reg, p_reg, q_reg, t_reg, cfg);
        add_res = (cmd.op.kind == OP_SUB) ? sat_add(opa, -opb) : sat_add(opa, opb);

        xs = mcnt_reg[0] ? x_reg[63:32] : x_reg[31:0];
        ys = mcnt_reg[1] ? y_reg[63:32] : y_reg[31:0];

        unique case (sh_reg)
            2'd0:    prod_sh = {64'd0, prod_reg};
            2'd3:    prod_sh = {prod_reg, 64'd0};
            default: prod_sh = {32'd0, prod_reg, 32'd0};
        endcase

        // truncate to 40 fraction bits, saturate when the integer part overflows
        if (|acc_reg[127:103])
            mul_mag = SAT_MAX;
        else
            mul_mag = acc_reg[103:40];
        mul_res = neg_reg ? -$signed(mul_mag) : $signed(mul_mag);

        we    = 1'b0;
        wdst  = dst_reg;
        wdata = mul_res;
        if (mbusy_reg && mcnt_reg == 3'd5)
            we = 1'b1;
        else if (cmd.start && cmd.op.kind != OP_MUL)
        begin
            we    = 1'b1;
            wdst  = cmd.op.dst;
            wdata = add_res;
        end

        re_next = (we && wdst == SRC_RE) ? wdata : re_reg;
        im_next = (we && wdst == SRC_IM) ? wdata : im_reg;
        if (cmd.load)
        begin
            re_next = x0;
            im_next = y0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            re_reg       <= '0;
            im_reg       <= '0;
            re2_reg      <= '0;
            im2_reg      <= '0;
            p_reg        <= '0;
            q_reg        <= '0;
            t_reg        <= '0;
            x_reg        <= '0;
            y_reg        <= '0;
            neg_reg      <= 1'b0;
            acc_reg      <= '0;
            prod_reg     <= '0;
            sh_reg       <= '0;
            mcnt_reg     <= '0;
            mbusy_reg    <= 1'b0;
            add_done_reg <= 1'b0;
            dst_reg      <= '0;
        end
        else
        begin
            re_reg       <= re_next;
            im_reg       <= im_next;
            add_done_reg <= cmd.start && cmd.op.kind != OP_MUL;
            if (we && wdst == SRC_RE2) re2_reg <= wdata;
            if (we && wdst == SRC_IM2) im2_reg <= wdata;
            if (we && wdst == SRC_P)   p_reg   <= wdata;
            if (we && wdst == SRC_Q)   q_reg   <= wdata;
            if (we && wdst == SRC_T)   t_reg   <= wdata;

            if (cmd.start && cmd.op.kind == OP_MUL)
            begin
                x_reg     <= (opa < 0) ? VAL_W'(-opa) : VAL_W'(opa);
                y_reg     <= (opb < 0) ? VAL_W'(-opb) : VAL_W'(opb);
                neg_reg   <= ((opa < 0) && !cmd.op.absa) != (opb < 0);
                acc_reg   <= '0;
                mcnt_reg  <= '0;
                mbusy_reg <= 1'b1;
                dst_reg   <= cmd.op.dst;
            end
            else if (mbusy_reg)
            begin
                // partial product is registered, then accumulated in the next cycle
                if (mcnt_reg < 3'd4)
                begin
                    prod_reg <= xs * ys;
                    sh_reg   <= mcnt_reg[1:0];
                end
                if (mcnt_reg >= 3'd1 && mcnt_reg <= 3'd4)
                    acc_reg <= acc_reg + prod_sh;
                if (mcnt_reg == 3'd5)
                    mbusy_reg <= 1'b0;
                mcnt_reg <= mcnt_reg + 3'd1;
            end
        end
    end

    assign stat.run  = (re_reg < LIM_RUN) || (im_reg < LIM_RUN);
    assign stat.hit  = (re_reg < LIM_RE) || (im_reg < LIM_IM);
    assign stat.done = (mbusy_reg && mcnt_reg == 3'd5) || add_done_reg;

endmodule

>>> rtl/core/bpi_ctrl.sv
// controller: iteration sequencer, step counter and result register
module bpi_ctrl
#(
    parameter int MAX_ITER = bpi_pkg::DEF_MAX_ITER
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    output logic           out_valid,
    input  logic           out_stall,
    output logic           hit,
    output logic [5:0]     iter_count,
    output bpi_pkg::cmd_t  cmd,
    input  bpi_pkg::stat_t stat
);
    import bpi_pkg::*;

    localparam int CNT_W = $clog2(MAX_ITER + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_TEST  = 3'd1;
    localparam logic [2:0] S_ISSUE = 3'd2;
    localparam logic [2:0] S_WAIT  = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [PC_W-1:0]  pc_reg, pc_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic             hit_reg, hit_next;
    logic [5:0]       iter_reg, iter_next;

    always_comb
    begin
        state_next     = state_reg;
        pc_next        = pc_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        hit_next       = hit_reg;
        iter_next      = iter_reg;
        cmd.load       = 1'b0;
        cmd.start      = 1'b0;
        cmd.op         = prog_rom(pc_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = S_TEST;
                end
            end
            S_TEST:
            begin
                pc_next = '0;
                if (stat.run && cnt_reg < CNT_W'(MAX_ITER))
                    state_next = S_ISSUE;
                else
                    state_next = S_DONE;
            end
            S_ISSUE:
            begin
                cmd.start  = 1'b1;
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (stat.done)
                begin
                    if (pc_reg == LAST_PC)
                    begin
                        cnt_next   = cnt_reg + 1'b1;
                        state_next = S_TEST;
                    end
                    else
                    begin
                        pc_next    = pc_reg + 1'b1;
                        state_next = S_ISSUE;
                    end
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    hit_next       = stat.hit;
                    iter_next      = 6'(cnt_reg);
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pc_reg        <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
            iter_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            hit_reg       <= hit_next;
            iter_reg      <= iter_next;
        end
    end

    assign in_stall   = (state_reg != S_IDLE);
    assign out_valid  = out_valid_reg;
    assign hit        = hit_reg;
    assign iter_count = iter_reg;

endmodule

>>> rtl/core/biomorph_pixel_iterator.sv
// top level of the cubic biomorph pixel iterator
// usage:
//   input channel (in_valid / in_stall) carries one pixel coordinate per
//   transaction: pixel_x, pixel_y, signed, relative to the image center
//   output channel (out_valid / out_stall) carries one result per input
//   transaction: hit flag and iter_count (steps run, capped at MAX_ITER)
//   config port: cfg_we writes cfg_data into register cfg_index
//   (0 const_re, 1 const_im, 2 offset_x, 3 offset_y, 4 zoom_factor,
//   5 pixel_step); other indexes are dropped; write only while idle
// timing:
//   one pixel at a time; in_stall stays high from acceptance until the
//   result is placed in the output register
//   each step runs a 16-entry micro-program on one shared 32x32 multiplier:
//   8 q24.40 multiplies and 8 saturating adds, plus one loop test
// reset: all control clears, config registers return to their defaults
// when the receiver stalls, the result holds in the output register and
// the next pixel is still accepted; its result waits until that slot frees
module biomorph_pixel_iterator
#(
    parameter int MAX_ITER = bpi_pkg::DEF_MAX_ITER
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_index,
    input  logic [31:0]       cfg_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic signed [9:0] pixel_x,
    input  logic signed [9:0] pixel_y,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              hit,
    output logic [5:0]        iter_count
);
    import bpi_pkg::*;

    cfg_t  cfg_reg;
    cmd_t  cmd;
    stat_t stat;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.const_re    <= -32'sd11744051;
            cfg_reg.const_im    <= 32'sd1678;
            cfg_reg.offset_x    <= '0;
            cfg_reg.offset_y    <= '0;
            cfg_reg.zoom_factor <= 31'd16777216;
            cfg_reg.pixel_step  <= 31'd117440;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CONST_RE: cfg_reg.const_re    <= cfg_data;
                REG_CONST_IM: cfg_reg.const_im    <= cfg_data;
                REG_OFFSET_X: cfg_reg.offset_x    <= cfg_data;
                REG_OFFSET_Y: cfg_reg.offset_y    <= cfg_data;
                REG_ZOOM:     cfg_reg.zoom_factor <= cfg_data[30:0];
                REG_STEP:     cfg_reg.pixel_step  <= cfg_data[30:0];
                default:      ; // unused index, write dropped
            endcase
        end
    end

    // sequencer
    bpi_ctrl #(
        .MAX_ITER (MAX_ITER)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .hit        (hit),
        .iter_count (iter_count),
        .cmd        (cmd),
        .stat       (stat)
    );

    // arithmetic
    bpi_datapath u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .cmd     (cmd),
        .pixel_x (pixel_x),
        .pixel_y (pixel_y),
        .stat    (stat)
    );

endmodule

>>> rtl/core/bpi_checker.sv
// port-level checker for the biomorph pixel iterator and its bind
module bpi_checker
#(
    parameter int MAX_ITER = bpi_pkg::DEF_MAX_ITER
)
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic       hit,
    input logic [5:0] iter_count
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(iter_count) && $stable(hit))
        else $error("stalled result changed");

    // one pixel in flight: busy right after an accepted transaction
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not stalled after accept");

    // step count never exceeds the cap
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> iter_count <= 6'(MAX_ITER))
        else $error("iteration count above cap");

    // a new result only appears after work: an accept with no result held leaves out_valid low
    a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !out_valid |=> !out_valid)
        else $error("result without iteration");

endmodule

bind biomorph_pixel_iterator bpi_checker #(
    .MAX_ITER (MAX_ITER)
) u_bpi_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .hit        (hit),
    .iter_count (iter_count)
);
